### rtl/bwa_pkg.sv
package bwa_pkg;

  localparam int LONG_WINDOW_DEF  = 39;
  localparam int SHORT_WINDOW_DEF = 19;

  localparam int TICK_W      = 16;
  localparam int TEMP_W      = 9;
  localparam int RH_W        = 7;
  localparam int SHORT_LIM_W = 5;
  localparam int LONG_LIM_W  = 6;
  localparam int LEVEL_W     = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 7;
  localparam int PROD_W      = 24;
  localparam int QUOT_W      = 8;
  localparam int GROUP_W     = 8;

  localparam logic [7:0]          TEMP_SCALE  = 8'd175;
  localparam logic [7:0]          RH_SCALE    = 8'd125;
  localparam logic [TEMP_W-1:0]   TEMP_OFFSET = 9'd45;
  localparam logic [QUOT_W-1:0]   RH_OFFSET   = 8'd6;
  localparam logic [QUOT_W-1:0]   RH_TOP      = 8'd106;
  localparam logic [RH_W-1:0]     RH_MAX      = 7'd100;

  localparam logic [CFG_IDX_W-1:0] REG_RH_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_LIMIT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_LIMIT   = 2'd2;

  localparam logic [RH_W-1:0]        RH_THRESHOLD_RST = 7'd79;
  localparam logic [SHORT_LIM_W-1:0] SHORT_LIMIT_RST  = 5'd5;
  localparam logic [LONG_LIM_W-1:0]  LONG_LIMIT_RST   = 6'd10;

  localparam logic [LEVEL_W-1:0] LEVEL_NORMAL = 2'd0;
  localparam logic [LEVEL_W-1:0] LEVEL_LOW    = 2'd1;
  localparam logic [LEVEL_W-1:0] LEVEL_NONE   = 2'd2;

  localparam logic [LEVEL_W-1:0] ALARM_CALM   = 2'd0;
  localparam logic [LEVEL_W-1:0] ALARM_YELLOW = 2'd1;
  localparam logic [LEVEL_W-1:0] ALARM_RED    = 2'd2;

  typedef struct packed {
    logic short_hit;
    logic long_hit;
  } bwa_check_t;

  // floor(x / 65535) for x below 2^24: the remainder after the shift estimate
  // stays below twice the divisor, so one correction step is enough
  function automatic logic [QUOT_W-1:0] div_full_scale(input logic [PROD_W-1:0] x);
    logic [QUOT_W-1:0] q0;
    logic [16:0]       r;
    q0 = x[PROD_W-1:16];
    r  = {1'b0, x[15:0]} + {9'd0, q0};
    return (r >= 17'd65535) ? q0 + 8'd1 : q0;
  endfunction

  function automatic logic [LEVEL_W-1:0] classify(input logic [7:0] count,
                                                  input logic [7:0] limit);
    if (count == 8'd0) return LEVEL_NONE;
    if (count < limit) return LEVEL_LOW;
    return LEVEL_NORMAL;
  endfunction

  function automatic logic [LEVEL_W-1:0] level_to_alarm(input logic [LEVEL_W-1:0] level);
    logic [LEVEL_W-1:0] a;
    unique case (level)
      LEVEL_NONE: a = ALARM_RED;
      LEVEL_LOW:  a = ALARM_YELLOW;
      default:    a = ALARM_CALM;
    endcase
    return a;
  endfunction

endpackage

### rtl/bwa_if.sv
interface bwa_in_if import bwa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TICK_W-1:0] temp_ticks;
  logic [TICK_W-1:0] humidity_ticks;

  modport source (output valid, temp_ticks, humidity_ticks, input ready);
  modport sink   (input valid, temp_ticks, humidity_ticks, output ready);
endinterface

interface bwa_out_if import bwa_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [TEMP_W-1:0] temp_celsius;
  logic [RH_W-1:0]          humidity_percent;
  logic                     short_checked;
  logic [LEVEL_W-1:0]       short_level;
  logic                     long_checked;
  logic [LEVEL_W-1:0]       long_level;
  logic [LEVEL_W-1:0]       alarm_level;

  modport source (output valid, temp_celsius, humidity_percent, short_checked, short_level,
                  long_checked, long_level, alarm_level, input ready);
  modport sink   (input valid, temp_celsius, humidity_percent, short_checked, short_level,
                  long_checked, long_level, alarm_level, output ready);
endinterface

interface bwa_cfg_if import bwa_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/bwa_conv.sv
module bwa_conv import bwa_pkg::*; (
  input  logic                     clk,
  input  logic                     load,
  input  logic [TICK_W-1:0]        temp_ticks,
  input  logic [TICK_W-1:0]        humidity_ticks,
  output logic signed [TEMP_W-1:0] temp_celsius,
  output logic [RH_W-1:0]          humidity_percent
);

  logic [PROD_W-1:0] prod_temp;
  logic [PROD_W-1:0] prod_rh;
  logic [QUOT_W-1:0] temp_q;
  logic [QUOT_W-1:0] rh_q;

  always_ff @(posedge clk) begin
    if (load) begin
      prod_temp <= PROD_W'(temp_ticks) * PROD_W'(TEMP_SCALE);
      prod_rh   <= PROD_W'(humidity_ticks) * PROD_W'(RH_SCALE);
    end
  end

  always_comb begin
    temp_q       = div_full_scale(prod_temp);
    rh_q         = div_full_scale(prod_rh);
    temp_celsius = $signed({1'b0, temp_q}) - $signed(TEMP_OFFSET);
    if (rh_q < RH_OFFSET) begin
      humidity_percent = '0;
    end else if (rh_q > RH_TOP) begin
      humidity_percent = RH_MAX;
    end else begin
      humidity_percent = RH_W'(rh_q - RH_OFFSET);
    end
  end

endmodule

### rtl/bwa_cell.sv
module bwa_cell import bwa_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            shift,
  input  logic [RH_W-1:0] d,
  input  logic [RH_W-1:0] threshold,
  output logic [RH_W-1:0] q,
  output logic            above
);

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (shift) begin
      q <= d;
    end
  end

  // compare on the value entering the cell, so the flag matches the shifted history
  assign above = d > threshold;

endmodule

### rtl/bwa_count.sv
module bwa_count import bwa_pkg::*; #(
  parameter int LONG_WINDOW  = LONG_WINDOW_DEF,
  parameter int SHORT_WINDOW = SHORT_WINDOW_DEF,
  localparam int CW = $clog2(LONG_WINDOW + 1)
) (
  input  logic                   clk,
  input  logic                   load,
  input  logic [LONG_WINDOW-1:0] flags,
  output logic [CW-1:0]          short_count,
  output logic [CW-1:0]          long_count
);

  localparam int SPAN  = (SHORT_WINDOW < LONG_WINDOW) ? SHORT_WINDOW : LONG_WINDOW;
  localparam int NG    = (LONG_WINDOW + GROUP_W - 1) / GROUP_W;
  localparam int PAD_W = NG * GROUP_W;
  localparam int GCW   = $clog2(GROUP_W + 1);

  logic [PAD_W-1:0] flags_pad;
  logic [GCW-1:0]   grp_long_next  [NG];
  logic [GCW-1:0]   grp_short_next [NG];
  logic [GCW-1:0]   grp_long       [NG];
  logic [GCW-1:0]   grp_short      [NG];

  always_comb begin
    flags_pad = PAD_W'(flags);
    for (int g = 0; g < NG; g++) begin
      grp_long_next[g]  = '0;
      grp_short_next[g] = '0;
      for (int j = 0; j < GROUP_W; j++) begin
        if (flags_pad[g * GROUP_W + j]) begin
          grp_long_next[g] = grp_long_next[g] + GCW'(1);
          if (g * GROUP_W + j < SPAN) begin
            grp_short_next[g] = grp_short_next[g] + GCW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      grp_long  <= grp_long_next;
      grp_short <= grp_short_next;
    end
  end

  always_comb begin
    short_count = '0;
    long_count  = '0;
    for (int g = 0; g < NG; g++) begin
      short_count = short_count + CW'(grp_short[g]);
      long_count  = long_count + CW'(grp_long[g]);
    end
  end

endmodule

### rtl/breath_window_alarm.sv
// Breath window alarm. Takes one sensor reading per cycle while the result side
// is not stalled, and gives one result per reading. The pipeline is a multiply
// stage, a stage that finishes the unit conversion and shifts the humidity
// history (a row of cells, one sample each), a stage that counts samples above
// threshold in groups of eight, and the output register that sums the groups,
// classifies and updates the latched alarm. The history clears at reset; no
// clearing pass is needed. Configuration writes are always taken. The threshold
// is used at the history stage and the limits at the output stage, so write only
// with no reading in flight.
module breath_window_alarm import bwa_pkg::*; #(
  parameter int LONG_WINDOW  = LONG_WINDOW_DEF,
  parameter int SHORT_WINDOW = SHORT_WINDOW_DEF
) (
  input logic       clk,
  input logic       rst,
  bwa_in_if.sink    samples,
  bwa_out_if.source results,
  bwa_cfg_if.sink   cfg
);

  localparam int PW = $clog2(LONG_WINDOW + 1);
  localparam int CW = $clog2(LONG_WINDOW + 1);

  // configuration
  logic [RH_W-1:0]        rh_threshold;
  logic [SHORT_LIM_W-1:0] short_low_limit;
  logic [LONG_LIM_W-1:0]  long_low_limit;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rh_threshold    <= RH_THRESHOLD_RST;
      short_low_limit <= SHORT_LIMIT_RST;
      long_low_limit  <= LONG_LIMIT_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_RH_THRESHOLD: rh_threshold    <= cfg.data;
        REG_SHORT_LIMIT:  short_low_limit <= cfg.data[SHORT_LIM_W-1:0];
        REG_LONG_LIMIT:   long_low_limit  <= cfg.data[LONG_LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // stage handshake
  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4 = !v4 || results.ready;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign samples.ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) v1 <= samples.valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
    end
  end

  // stage 1: multiply; stage 2 input: converted values
  logic signed [TEMP_W-1:0] temp_conv;
  logic [RH_W-1:0]          rh_conv;
  logic                     shift;

  assign shift = v1 && rdy2;

  bwa_conv u_conv (
    .clk              (clk),
    .load             (samples.valid && rdy1),
    .temp_ticks       (samples.temp_ticks),
    .humidity_ticks   (samples.humidity_ticks),
    .temp_celsius     (temp_conv),
    .humidity_percent (rh_conv)
  );

  // history cells
  logic [RH_W-1:0]        hist [LONG_WINDOW];
  logic [LONG_WINDOW-1:0] above;

  for (genvar i = 0; i < LONG_WINDOW; i++) begin : g_cell
    bwa_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .shift     (shift),
      .d         ((i == 0) ? rh_conv : hist[(i == 0) ? 0 : i - 1]),
      .threshold (rh_threshold),
      .q         (hist[i]),
      .above     (above[i])
    );
  end

  // phase counter advances with the history
  logic [PW-1:0] phase;
  bwa_check_t    check_next;

  always_comb begin
    check_next.short_hit = (int'(phase) == SHORT_WINDOW) || (int'(phase) == LONG_WINDOW);
    check_next.long_hit  = int'(phase) == LONG_WINDOW;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else if (shift) begin
      phase <= check_next.long_hit ? '0 : phase + PW'(1);
    end
  end

  // stage 2 registers
  logic signed [TEMP_W-1:0] temp2;
  logic [RH_W-1:0]          rh2;
  logic [LONG_WINDOW-1:0]   flags2;
  bwa_check_t               check2;

  always_ff @(posedge clk) begin
    if (shift) begin
      temp2  <= temp_conv;
      rh2    <= rh_conv;
      flags2 <= above;
      check2 <= check_next;
    end
  end

  // stage 3: group counts
  logic signed [TEMP_W-1:0] temp3;
  logic [RH_W-1:0]          rh3;
  bwa_check_t               check3;
  logic [CW-1:0]            short_count;
  logic [CW-1:0]            long_count;

  bwa_count #(
    .LONG_WINDOW  (LONG_WINDOW),
    .SHORT_WINDOW (SHORT_WINDOW)
  ) u_count (
    .clk         (clk),
    .load        (v2 && rdy3),
    .flags       (flags2),
    .short_count (short_count),
    .long_count  (long_count)
  );

  always_ff @(posedge clk) begin
    if (v2 && rdy3) begin
      temp3  <= temp2;
      rh3    <= rh2;
      check3 <= check2;
    end
  end

  // stage 4: classify and latch alarm
  logic [LEVEL_W-1:0] alarm;
  logic [LEVEL_W-1:0] alarm_next;
  logic [LEVEL_W-1:0] short_level_next;
  logic [LEVEL_W-1:0] long_level_next;
  logic               load4;

  assign load4 = v3 && rdy4;

  always_comb begin
    short_level_next = LEVEL_NORMAL;
    long_level_next  = LEVEL_NORMAL;
    alarm_next       = alarm;
    if (check3.short_hit) begin
      short_level_next = classify(8'(short_count), 8'(short_low_limit));
      alarm_next       = level_to_alarm(short_level_next);
    end
    if (check3.long_hit) begin
      long_level_next = classify(8'(long_count), 8'(long_low_limit));
      alarm_next      = level_to_alarm(long_level_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      alarm <= ALARM_CALM;
    end else if (load4) begin
      alarm <= alarm_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load4) begin
      results.temp_celsius     <= temp3;
      results.humidity_percent <= rh3;
      results.short_checked    <= check3.short_hit;
      results.short_level      <= short_level_next;
      results.long_checked     <= check3.long_hit;
      results.long_level       <= long_level_next;
      results.alarm_level      <= alarm_next;
    end
  end

  assign results.valid = v4;

  // checks
  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    int'(phase) <= LONG_WINDOW)
    else $error("phase counter past long window");

  a_long_implies_short: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.long_checked |-> results.short_checked)
    else $error("long check without short check");

  a_alarm_long: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.long_checked |->
      results.alarm_level == level_to_alarm(results.long_level))
    else $error("alarm does not follow long check");

  a_alarm_short: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.short_checked && !results.long_checked |->
      results.alarm_level == level_to_alarm(results.short_level))
    else $error("alarm does not follow short check");

  a_alarm_held: assert property (@(posedge clk) disable iff (rst)
    load4 && !check3.short_hit |=> alarm == $past(alarm))
    else $error("alarm changed without a check");

endmodule
